// ----- rtl/core/moravec_corner_confidence_top_assert.svh -----
// Assertion macros for the corner confidence block.
// Each expects i_clk and i_rst_n in scope at the point of use.
`ifndef MORAVEC_CORNER_CONFIDENCE_TOP_ASSERT_SVH
`define MORAVEC_CORNER_CONFIDENCE_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("corner confidence check failed");

// Consequent holds in the cycle after the antecedent.
`define MCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("corner confidence check failed");

`endif

// ----- rtl/core/mcc_pkg.sv -----
package mcc_pkg;

    localparam int PIX_W      = 8;
    localparam int WIN        = 5;
    localparam int LINES      = 4;
    localparam int PATCH      = 3;
    localparam int NDIR       = 4;
    localparam int SQ_W       = 16;
    localparam int PS_W       = 18;
    localparam int CONF_W     = 20;
    localparam int COORD_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int MIN_SIZE   = 5;
    localparam int MAX_HEIGHT = 1024;
    // Border width: a centre needs two pixels on every side.
    localparam int BORDER     = 2;

    // Direction slots of the squared-difference set.
    localparam int DIR_DN = 0;
    localparam int DIR_UP = 1;
    localparam int DIR_LF = 2;
    localparam int DIR_RT = 3;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [CONF_W-1:0] THRESH_RST = 20'd15000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    typedef logic [NDIR-1:0][PATCH-1:0][PATCH-1:0][SQ_W-1:0] t_sq_set;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } t_meta;

    function automatic logic [SQ_W-1:0] sq_absdiff(input t_pix a, input t_pix b);
        logic [PIX_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// ----- rtl/core/mcc_line_buf.sv -----
module mcc_line_buf #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/mcc_window.sv -----
module mcc_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mcc_pkg::t_pix               i_pixel,
    input  logic [mcc_pkg::SIZE_W-1:0]  i_width,
    input  logic [mcc_pkg::SIZE_W-1:0]  i_height,
    input  logic                        i_take,
    output logic                        o_s1_valid,
    output mcc_pkg::t_sq_set            o_s1_sq,
    output mcc_pkg::t_meta              o_s1_meta
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WORD  = mcc_pkg::LINES * mcc_pkg::PIX_W;

    logic [CW-1:0]                  r_col, n_col, w_last, rd_addr, col_m2;
    logic [mcc_pkg::COORD_W-1:0]    r_row, n_row, h_last;
    mcc_pkg::t_pix                  r_win [mcc_pkg::WIN][mcc_pkg::WIN];
    mcc_pkg::t_pix                  n_win [mcc_pkg::WIN][mcc_pkg::WIN];
    logic [WORD-1:0]                rd_data, wr_data;
    logic                           accept, emit, r_v1;
    mcc_pkg::t_sq_set               n_sq, r_sq;
    mcc_pkg::t_meta                 n_meta, r_meta;

    assign o_in_ready = !r_v1 || i_take;
    assign accept     = i_in_valid && o_in_ready;

    // Clamp the frame size to at least MIN_SIZE and to what the line store and row counter can hold.
    always_comb begin
        if (i_width < mcc_pkg::SIZE_W'(mcc_pkg::MIN_SIZE)) begin
            w_last = CW'(mcc_pkg::MIN_SIZE - 1);
        end else if (32'(i_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(i_width - mcc_pkg::SIZE_W'(1));
        end
        if (i_height < mcc_pkg::SIZE_W'(mcc_pkg::MIN_SIZE)) begin
            h_last = mcc_pkg::COORD_W'(mcc_pkg::MIN_SIZE - 1);
        end else if (i_height > mcc_pkg::SIZE_W'(mcc_pkg::MAX_HEIGHT)) begin
            h_last = mcc_pkg::COORD_W'(mcc_pkg::MAX_HEIGHT - 1);
        end else begin
            h_last = mcc_pkg::COORD_W'(i_height - mcc_pkg::SIZE_W'(1));
        end
    end

    always_comb begin
        if (r_col >= w_last) begin
            n_col = '0;
            n_row = (r_row >= h_last) ? '0 : r_row + mcc_pkg::COORD_W'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // Read one address ahead so the column of the next pixel is waiting.
    assign rd_addr = !i_rst_n ? '0 : (accept ? n_col : r_col);

    mcc_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (WORD)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Shift the window left and bring in the new column.
    always_comb begin
        for (int k = 0; k < mcc_pkg::WIN; k++) begin
            for (int x = 0; x < mcc_pkg::WIN - 1; x++) begin
                n_win[k][x] = r_win[k][x+1];
            end
            if (k < mcc_pkg::LINES) begin
                n_win[k][mcc_pkg::WIN-1] = rd_data[k*mcc_pkg::PIX_W +: mcc_pkg::PIX_W];
            end else begin
                n_win[k][mcc_pkg::WIN-1] = i_pixel;
            end
        end
        for (int k = 0; k < mcc_pkg::LINES; k++) begin
            wr_data[k*mcc_pkg::PIX_W +: mcc_pkg::PIX_W] = n_win[k+1][mcc_pkg::WIN-1];
        end
    end

    always_comb begin
        for (int j = 0; j < mcc_pkg::PATCH; j++) begin
            for (int i = 0; i < mcc_pkg::PATCH; i++) begin
                n_sq[mcc_pkg::DIR_DN][j][i] = mcc_pkg::sq_absdiff(n_win[j+2][i+1], n_win[j+1][i+1]);
                n_sq[mcc_pkg::DIR_UP][j][i] = mcc_pkg::sq_absdiff(n_win[j][i+1],   n_win[j+1][i+1]);
                n_sq[mcc_pkg::DIR_LF][j][i] = mcc_pkg::sq_absdiff(n_win[j+1][i],   n_win[j+1][i+1]);
                n_sq[mcc_pkg::DIR_RT][j][i] = mcc_pkg::sq_absdiff(n_win[j+1][i+2], n_win[j+1][i+1]);
            end
        end
    end

    assign emit = (r_row >= mcc_pkg::COORD_W'(2 * mcc_pkg::BORDER))
               && (r_col >= CW'(2 * mcc_pkg::BORDER));
    assign col_m2 = r_col - CW'(mcc_pkg::BORDER);

    always_comb begin
        n_meta.row  = r_row - mcc_pkg::COORD_W'(mcc_pkg::BORDER);
        n_meta.col  = mcc_pkg::COORD_W'(col_m2);
        n_meta.last = (r_row == h_last) && (r_col == w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_v1  <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (o_in_ready) begin
                r_v1 <= accept && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win  <= n_win;
            r_sq   <= n_sq;
            r_meta <= n_meta;
        end
    end

    assign o_s1_valid = r_v1;
    assign o_s1_sq    = r_sq;
    assign o_s1_meta  = r_meta;

endmodule

// ----- rtl/core/mcc_reduce.sv -----
module mcc_reduce (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    input  mcc_pkg::t_sq_set            i_s1_sq,
    input  mcc_pkg::t_meta              i_s1_meta,
    output logic                        o_take,
    input  logic [mcc_pkg::CONF_W-1:0]  i_thresh,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mcc_pkg::CONF_W-1:0]  o_confidence,
    output logic [mcc_pkg::COORD_W-1:0] o_center_row,
    output logic [mcc_pkg::COORD_W-1:0] o_center_col,
    output logic                        o_is_feature,
    output logic                        o_frame_last
);

    logic [mcc_pkg::NDIR-1:0][mcc_pkg::PATCH-1:0][mcc_pkg::PS_W-1:0] n_ps, r_ps;
    logic [mcc_pkg::NDIR-1:0][mcc_pkg::CONF_W-1:0] n_tot, r_tot;
    logic [1:0][mcc_pkg::CONF_W-1:0]               n_pm, r_pm;
    logic [mcc_pkg::CONF_W-1:0]                    n_conf, r_conf;
    mcc_pkg::t_meta                                r_m2, r_m3, r_m4, r_mo;
    logic r_v2, r_v3, r_v4, r_ov, r_feat;
    logic rdy2, rdy3, rdy4, rdy_out;

    // Each stage advances when it is empty or the one after it moves.
    assign rdy_out = !r_ov || i_out_ready;
    assign rdy4    = !r_v4 || rdy_out;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_take  = rdy2;

    always_comb begin
        for (int d = 0; d < mcc_pkg::NDIR; d++) begin
            for (int j = 0; j < mcc_pkg::PATCH; j++) begin
                n_ps[d][j] = mcc_pkg::PS_W'(i_s1_sq[d][j][0])
                           + mcc_pkg::PS_W'(i_s1_sq[d][j][1])
                           + mcc_pkg::PS_W'(i_s1_sq[d][j][2]);
            end
            n_tot[d] = mcc_pkg::CONF_W'(r_ps[d][0])
                     + mcc_pkg::CONF_W'(r_ps[d][1])
                     + mcc_pkg::CONF_W'(r_ps[d][2]);
        end
        n_pm[0] = (r_tot[mcc_pkg::DIR_UP] < r_tot[mcc_pkg::DIR_DN])
                ? r_tot[mcc_pkg::DIR_UP] : r_tot[mcc_pkg::DIR_DN];
        n_pm[1] = (r_tot[mcc_pkg::DIR_RT] < r_tot[mcc_pkg::DIR_LF])
                ? r_tot[mcc_pkg::DIR_RT] : r_tot[mcc_pkg::DIR_LF];
        n_conf  = (r_pm[1] < r_pm[0]) ? r_pm[1] : r_pm[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_s1_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy_out) begin
                r_ov <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_s1_valid) begin
            r_ps <= n_ps;
            r_m2 <= i_s1_meta;
        end
        if (rdy3 && r_v2) begin
            r_tot <= n_tot;
            r_m3  <= r_m2;
        end
        if (rdy4 && r_v3) begin
            r_pm <= n_pm;
            r_m4 <= r_m3;
        end
        if (rdy_out && r_v4) begin
            r_conf <= n_conf;
            r_feat <= (n_conf >= i_thresh);
            r_mo   <= r_m4;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_confidence = r_conf;
    assign o_center_row = r_mo.row;
    assign o_center_col = r_mo.col;
    assign o_is_feature = r_feat;
    assign o_frame_last = r_mo.last;

endmodule

// ----- rtl/core/moravec_corner_confidence_top.sv -----
// Channel   Direction  Handshake                    Payload
// pixel     in         i_in_valid / o_in_ready      i_pixel
// result    out        o_out_valid / i_out_ready    o_confidence, o_center_row,
//                                                   o_center_col, o_is_feature,
//                                                   o_frame_last
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One pixel transfer per cycle while o_in_ready is high; the pixel that completes
// a window sends its result through registers for squares, row sums, totals, pair
// minimum and final minimum. The line store is read one address ahead of the
// column counter, so its single read port sets the one-pixel-per-cycle rate.
// Reset is synchronous and active low; the line store needs no clearing pass.
// A stalled result only stalls input once every pipeline stage is occupied.
module moravec_corner_confidence_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel stream
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mcc_pkg::PIX_W-1:0]     i_pixel,
    // results
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mcc_pkg::CONF_W-1:0]    o_confidence,
    output logic [mcc_pkg::COORD_W-1:0]   o_center_row,
    output logic [mcc_pkg::COORD_W-1:0]   o_center_col,
    output logic                          o_is_feature,
    output logic                          o_frame_last,
    // register writes
    input  logic                          i_cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mcc_pkg::CFG_W-1:0]     i_cfg_data
);

`include "moravec_corner_confidence_top_assert.svh"

    logic [mcc_pkg::SIZE_W-1:0] r_width, r_height;
    logic [mcc_pkg::CONF_W-1:0] r_thresh;

    logic             w_s1_valid;
    logic             w_take;
    mcc_pkg::t_sq_set w_s1_sq;
    mcc_pkg::t_meta   w_s1_meta;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mcc_pkg::WIDTH_RST;
            r_height <= mcc_pkg::HEIGHT_RST;
            r_thresh <= mcc_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            case (mcc_pkg::t_reg_idx'(i_cfg_idx))
                mcc_pkg::REG_WIDTH:  r_width  <= i_cfg_data[mcc_pkg::SIZE_W-1:0];
                mcc_pkg::REG_HEIGHT: r_height <= i_cfg_data[mcc_pkg::SIZE_W-1:0];
                mcc_pkg::REG_THRESH: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Line store, 5x5 window, raster counters and the squared differences.
    mcc_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pixel    (i_pixel),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_take     (w_take),
        .o_s1_valid (w_s1_valid),
        .o_s1_sq    (w_s1_sq),
        .o_s1_meta  (w_s1_meta)
    );

    // Sums, minimum and threshold, ending in the result register.
    mcc_reduce u_reduce (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (w_s1_valid),
        .i_s1_sq      (w_s1_sq),
        .i_s1_meta    (w_s1_meta),
        .o_take       (w_take),
        .i_thresh     (r_thresh),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_confidence (o_confidence),
        .o_center_row (o_center_row),
        .o_center_col (o_center_col),
        .o_is_feature (o_is_feature),
        .o_frame_last (o_frame_last)
    );

    // A blocked first stage must hold input off and keep its item.
    `MCC_ASSERT_NOW(a_s1_blocks_input, w_s1_valid && !w_take, !o_in_ready)
    `MCC_ASSERT_NEXT(a_s1_holds, w_s1_valid && !w_take, w_s1_valid)
    // With the result register empty, the sum pipeline always moves.
    `MCC_ASSERT_NOW(a_drain_free, !o_out_valid, w_take)
    // Results only come from centres at least two rows down.
    `MCC_ASSERT_NOW(a_row_border, o_out_valid, o_center_row >= mcc_pkg::COORD_W'(mcc_pkg::BORDER))

endmodule
